// ===== rtl/core/csvt_pkg.sv =====
// Shared types, constants and helpers for the CSV record tokenizer.
package csvt_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [UNIT_W-1:0]  LINE_FEED      = 16'd10;
    localparam logic [COUNT_W-1:0] MAX_FIELDS     = 9'd256;
    localparam logic [UNIT_W-1:0]  RST_SEPARATOR  = 16'd44;
    localparam logic [UNIT_W-1:0]  RST_QUOTE      = 16'd34;
    localparam logic [COUNT_W-1:0] RST_EXPECTED   = 9'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEPARATOR = 2'd0,
        CFG_QUOTE     = 2'd1,
        CFG_EXPECTED  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [UNIT_W-1:0]  separator_char;
        logic [UNIT_W-1:0]  quote_char;
        logic [COUNT_W-1:0] expected_fields;
    } t_cfg;

    typedef struct packed {
        logic               inside_quotes;
        logic               quote_pending;
        logic               quote_parity;
        logic               field_has_data;
        logic               last_was_separator;
        logic [COUNT_W-1:0] fields_closed;
    } t_state;

    typedef struct packed {
        logic               data_valid;
        logic [UNIT_W-1:0]  data_unit;
        logic               field_end;
        logic               record_end;
        logic [COUNT_W-1:0] field_count;
        logic               record_match;
    } t_result;

    // Saturating field counter increment.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
        sat_inc = (cnt < MAX_FIELDS) ? cnt + COUNT_W'(1) : cnt;
    endfunction

endpackage

// ===== rtl/core/csvt_cfg_regs.sv =====
// Configuration registers of the CSV record tokenizer.
module csvt_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [csvt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [csvt_pkg::UNIT_W-1:0]         i_cfg_data,
    output csvt_pkg::t_cfg                      o_cfg
);

    csvt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_char  <= csvt_pkg::RST_SEPARATOR;
            r_cfg.quote_char      <= csvt_pkg::RST_QUOTE;
            r_cfg.expected_fields <= csvt_pkg::RST_EXPECTED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csvt_pkg::CFG_SEPARATOR: r_cfg.separator_char <= i_cfg_data;
                csvt_pkg::CFG_QUOTE:     r_cfg.quote_char     <= i_cfg_data;
                csvt_pkg::CFG_EXPECTED:
                    r_cfg.expected_fields <= i_cfg_data[csvt_pkg::COUNT_W-1:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/csvt_core.sv =====
// Tokenizer state register and single-unit step logic.
module csvt_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [csvt_pkg::UNIT_W-1:0] i_code_unit,
    input  logic                        i_end_of_input,
    input  csvt_pkg::t_cfg              i_cfg,
    output csvt_pkg::t_result           o_result,
    output logic                        o_has_result
);

    csvt_pkg::t_state r_state;
    csvt_pkg::t_state n_state;

    always_comb begin
        logic in_record;
        logic is_quote;
        logic is_sep;
        n_state   = r_state;
        o_result  = '0;
        is_quote  = (i_code_unit == i_cfg.quote_char);
        is_sep    = (i_code_unit == i_cfg.separator_char);
        in_record = !((i_code_unit == csvt_pkg::LINE_FEED) && !r_state.quote_parity);

        if (in_record) begin
            if (is_quote) begin
                n_state.quote_parity = !r_state.quote_parity;
                if (r_state.quote_pending) begin
                    // doubled quote: emit one literal quote
                    o_result.data_valid    = 1'b1;
                    o_result.data_unit     = i_cfg.quote_char;
                    n_state.field_has_data = 1'b1;
                    n_state.quote_pending  = 1'b0;
                end else begin
                    n_state.quote_pending = 1'b1;
                end
            end else begin
                if (r_state.quote_pending) begin
                    n_state.inside_quotes = !r_state.inside_quotes;
                    n_state.quote_pending = 1'b0;
                end
                if (is_sep && !n_state.inside_quotes) begin
                    n_state.fields_closed  = csvt_pkg::sat_inc(n_state.fields_closed);
                    n_state.field_has_data = 1'b0;
                    o_result.field_end     = 1'b1;
                end else begin
                    o_result.data_valid    = 1'b1;
                    o_result.data_unit     = i_code_unit;
                    n_state.field_has_data = 1'b1;
                end
            end
            n_state.last_was_separator = is_sep;
        end

        if (!in_record || i_end_of_input) begin
            n_state.quote_pending = 1'b0;
            if (n_state.field_has_data || n_state.last_was_separator) begin
                n_state.fields_closed  = csvt_pkg::sat_inc(n_state.fields_closed);
                n_state.field_has_data = 1'b0;
                o_result.field_end     = 1'b1;
            end
            o_result.record_end = 1'b1;
        end

        o_result.field_count = n_state.fields_closed;
        if (o_result.record_end) begin
            o_result.record_match = (n_state.fields_closed == i_cfg.expected_fields);
            n_state = '0;
        end

        o_has_result = o_result.data_valid || o_result.field_end || o_result.record_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/csv_record_tokenizer.sv =====
// Top level of the CSV record tokenizer: input register, step logic, result register.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_code_unit, i_end_of_input
//  result    out        o_out_valid / i_out_stall  o_data_valid .. o_record_match
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One code unit per cycle sustained while the result port is not stalled; a unit's
// result passes through the input register, the step logic and the result register
// before it can transfer on the result port.
// The quote/field state loop closes through the combinational step logic.
// Reset is synchronous, active low; it clears state and restores defaults.
// A stalled result holds the result register; the input register then holds
// its unit and the input channel stalls. Units with no result pass silently.
module csv_record_tokenizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [csvt_pkg::UNIT_W-1:0]         i_code_unit,
    input  logic                                i_end_of_input,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_data_valid,
    output logic [csvt_pkg::UNIT_W-1:0]         o_data_unit,
    output logic                                o_field_end,
    output logic                                o_record_end,
    output logic [csvt_pkg::COUNT_W-1:0]        o_field_count,
    output logic                                o_record_match,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [csvt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [csvt_pkg::UNIT_W-1:0]         i_cfg_data
);

    csvt_pkg::t_cfg    w_cfg;
    csvt_pkg::t_result w_result;
    logic              w_has_result;
    logic              w_advance;

    logic                        r_in_valid;
    logic [csvt_pkg::UNIT_W-1:0] r_in_code_unit;
    logic                        r_in_eoi;
    logic                        r_out_valid;
    csvt_pkg::t_result           r_out;

    // Step the held unit when the result register is free or draining now.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    csvt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    csvt_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_code_unit    (r_in_code_unit),
        .i_end_of_input (r_in_eoi),
        .i_cfg          (w_cfg),
        .o_result       (w_result),
        .o_has_result   (w_has_result)
    );

    // Input register: load on every transfer, empty when stepped with no refill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_code_unit <= i_code_unit;
            r_in_eoi       <= i_end_of_input;
        end
    end

    // Result register: capture only steps that produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_valid   = r_out.data_valid;
    assign o_data_unit    = r_out.data_unit;
    assign o_field_end    = r_out.field_end;
    assign o_record_end   = r_out.record_end;
    assign o_field_count  = r_out.field_count;
    assign o_record_match = r_out.record_match;

    a_match_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_match |-> o_record_end)
        else $error("record match flagged outside record end");

    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_data_valid || o_field_end || o_record_end))
        else $error("result transferred with nothing to report");

    a_unit_zero_without_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_data_valid |-> (o_data_unit == '0))
        else $error("data unit nonzero without data valid");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_field_count <= csvt_pkg::MAX_FIELDS))
        else $error("field count beyond saturation limit");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while pipeline can advance");

endmodule

// ===== dv/csv_record_tokenizer_tb.sv =====
// Self-checking testbench for the CSV record tokenizer: directed and random text streams.
`timescale 1ns / 1ps

module csv_record_tokenizer_tb;
    import csvt_pkg::*;

    // Index past the three registers; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Cycles with no transfer on either channel before the run is abandoned.
    localparam int IDLE_LIMIT = 3000;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES = 150;
    // Quiet cycles after the last token, enough for a silent unit in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_UNITS = 280;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [UNIT_W-1:0]     i_code_unit = '0;
    logic                  i_end_of_input = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_data_valid;
    logic [UNIT_W-1:0]     o_data_unit;
    logic                  o_field_end;
    logic                  o_record_end;
    logic [COUNT_W-1:0]    o_field_count;
    logic                  o_record_match;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [UNIT_W-1:0]     i_cfg_data = '0;

    csv_record_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_code_unit    (i_code_unit),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_valid   (o_data_valid),
        .o_data_unit    (o_data_unit),
        .o_field_end    (o_field_end),
        .o_record_end   (o_record_end),
        .o_field_count  (o_field_count),
        .o_record_match (o_record_match),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Tokenizer copy kept by the testbench: registers and record state.
    logic [UNIT_W-1:0]  cfg_separator = RST_SEPARATOR;
    logic [UNIT_W-1:0]  cfg_quote     = RST_QUOTE;
    logic [COUNT_W-1:0] cfg_expected  = RST_EXPECTED;
    bit                 tk_inside_quotes;
    bit                 tk_quote_pending;
    bit                 tk_quote_parity;
    bit                 tk_field_has_data;
    bit                 tk_last_was_sep;
    logic [COUNT_W-1:0] tk_fields_closed = '0;

    // Tokens still owed by the block, oldest first.
    t_result token_fifo[$];

    // Knobs that shape traffic, set per test.
    bit sender_gaps   = 1'b0;
    bit result_stalls = 1'b0;
    bit hold_req      = 1'b0;
    bit holding       = 1'b0;

    int errors         = 0;
    int units_sent     = 0;
    int tokens_checked = 0;
    int records_seen   = 0;
    int matches_seen   = 0;
    int settings_used  = 0;

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic void close_current_field();
        if (tk_fields_closed < MAX_FIELDS)
            tk_fields_closed++;
        tk_field_has_data = 1'b0;
    endfunction

    function automatic void tokenize_unit(input logic [UNIT_W-1:0] cu, input logic eoi,
                                          output bit produced, output t_result tok);
        bit in_record;
        in_record = !(cu == LINE_FEED && !tk_quote_parity);
        tok = '0;
        if (in_record) begin
            if (cu == cfg_quote) begin
                // Second quote in a row gives a literal quote; a lone one waits.
                tk_quote_parity = !tk_quote_parity;
                if (tk_quote_pending) begin
                    tok.data_valid    = 1'b1;
                    tok.data_unit     = cfg_quote;
                    tk_field_has_data = 1'b1;
                    tk_quote_pending  = 1'b0;
                end else begin
                    tk_quote_pending = 1'b1;
                end
            end else begin
                // A pending quote followed by anything else flips quoting first.
                if (tk_quote_pending) begin
                    tk_inside_quotes = !tk_inside_quotes;
                    tk_quote_pending = 1'b0;
                end
                if (cu == cfg_separator && !tk_inside_quotes) begin
                    close_current_field();
                    tok.field_end = 1'b1;
                end else begin
                    tok.data_valid    = 1'b1;
                    tok.data_unit     = cu;
                    tk_field_has_data = 1'b1;
                end
            end
            tk_last_was_sep = (cu == cfg_separator);
        end
        if (!in_record || eoi) begin
            // Drop a pending quote and close the trailing field if it counts.
            tk_quote_pending = 1'b0;
            if (tk_field_has_data || tk_last_was_sep) begin
                close_current_field();
                tok.field_end = 1'b1;
            end
            tok.record_end = 1'b1;
        end
        tok.field_count = tk_fields_closed;
        if (tok.record_end) begin
            tok.record_match  = (tk_fields_closed == cfg_expected);
            tk_inside_quotes  = 1'b0;
            tk_quote_pending  = 1'b0;
            tk_quote_parity   = 1'b0;
            tk_field_has_data = 1'b0;
            tk_last_was_sep   = 1'b0;
            tk_fields_closed  = '0;
        end
        produced = tok.data_valid || tok.field_end || tok.record_end;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, check each result transfer.
    // Sampled at the rising edge, so every value seen is the pre-edge one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : transfer_monitor
        bit      produced;
        t_result tok;
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tokenize_unit(i_code_unit, i_end_of_input, produced, tok);
                if (produced)
                    token_fifo.push_back(tok);
            end
            if (o_out_valid && !i_out_stall) begin
                if (token_fifo.size() == 0) begin
                    $error("token transfer with none expected (unit 0x%0h)", o_data_unit);
                    errors++;
                end else begin
                    want = token_fifo.pop_front();
                    compare_field("data_valid", int'(want.data_valid), int'(o_data_valid));
                    compare_field("data_unit", int'(want.data_unit), int'(o_data_unit));
                    compare_field("field_end", int'(want.field_end), int'(o_field_end));
                    compare_field("record_end", int'(want.record_end), int'(o_record_end));
                    compare_field("field_count", int'(want.field_count),
                                  int'(o_field_count));
                    compare_field("record_match", int'(want.record_match),
                                  int'(o_record_match));
                    tokens_checked++;
                    if (want.record_end)
                        records_seen++;
                    if (want.record_match)
                        matches_seen++;
                end
            end
        end
    end

    // Watchdog: abandon the run when neither channel moves for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $error("no transfer for %0d cycles, %0d tokens outstanding",
                   IDLE_LIMIT, token_fifo.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, or one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_backpressure
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding = 1'b0;
            end else if (result_stalls && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one code unit and hold it until the transfer; maybe idle after.
    task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic eoi);
        i_in_valid     <= 1'b1;
        i_code_unit    <= cu;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        units_sent++;
        if (sender_gaps && $urandom_range(0, 9) < 3) begin
            i_in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s, input bit eoi_last);
        for (int k = 0; k < s.len(); k++)
            send_unit(UNIT_W'(s[k]), eoi_last && (k == s.len() - 1));
    endtask

    // Drop valid, wait for every owed token, then let silent units drain.
    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (token_fifo.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Call only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNIT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SEPARATOR: cfg_separator = data;
            CFG_QUOTE:     cfg_quote     = data;
            CFG_EXPECTED:  cfg_expected  = data[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [UNIT_W-1:0] sep, input logic [UNIT_W-1:0] quo,
                                  input logic [UNIT_W-1:0] expct);
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE, quo);
        write_reg(CFG_EXPECTED, expct);
        settings_used++;
    endtask

    // Field content: mostly letters, sometimes any code unit; quoted text
    // also carries separators and line feeds, unquoted text digits.
    function automatic logic [UNIT_W-1:0] text_unit(input bit quoted);
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return UNIT_W'(16'h61 + $urandom_range(0, 25));
        else if (r < 16)
            return UNIT_W'($urandom_range(0, 65535));
        else if (quoted && r < 18)
            return cfg_separator;
        else if (quoted)
            return LINE_FEED;
        return UNIT_W'(16'h30 + $urandom_range(0, 9));
    endfunction

    // One record of random fields under the current settings.
    task automatic send_record();
        int n_fields;
        int len;
        n_fields = $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0)
                send_unit(cfg_separator, 1'b0);
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                send_unit(cfg_quote, 1'b0);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send_unit(cfg_quote, 1'b0);
                        send_unit(cfg_quote, 1'b0);
                    end else begin
                        send_unit(text_unit(1'b1), 1'b0);
                    end
                end
                send_unit(cfg_quote, 1'b0);
            end else begin
                for (int k = 0; k < len; k++)
                    send_unit(text_unit(1'b0), 1'b0);
            end
        end
        // Close with a line feed, or now and then by end of input.
        if ($urandom_range(0, 9) == 0)
            send_unit($urandom_range(0, 1) ? LINE_FEED : text_unit(1'b0), 1'b1);
        else
            send_unit(LINE_FEED, 1'b0);
    endtask

    // A short burst of unstructured units: stray quotes, separators, breaks.
    task automatic send_noise();
        logic [UNIT_W-1:0] cu;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 4))
                0: cu = cfg_quote;
                1: cu = cfg_separator;
                2: cu = LINE_FEED;
                default: cu = UNIT_W'($urandom_range(0, 65535));
            endcase
            send_unit(cu, $urandom_range(0, 19) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Default separator and quote; each quoting rule and record-close case.
    task automatic test_basic_records();
        write_reg(CFG_EXPECTED, 16'd2);
        send_text("a,b\n", 1'b0);
        send_text("\"x\"\"y\",z\n", 1'b0);   // doubled quote is a literal
        send_text("\"p,\nq\"\n", 1'b0);      // separator and line feed in quotes
        send_text("\n", 1'b0);               // empty record
        send_text("a,\n", 1'b0);             // trailing separator adds a field
        send_text("\"", 1'b1);               // quote still pending at end of input
        send_text(",", 1'b1);                // separator as the final unit
        send_text("\"ab", 1'b1);             // end of input inside open quotes
        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        wait_for_quiet();
    endtask

    // Extreme register values, masking, the spare index, quote equal to separator.
    task automatic test_register_extremes();
        apply_settings(16'h0000, 16'hFFFF, 16'hFE01);
        write_reg(CFG_SPARE, UNIT_W'($urandom_range(0, 65535)));
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(LINE_FEED, 1'b0);
        wait_for_quiet();
        apply_settings(16'd59, 16'd59, 16'd0);
        send_text(";a;;b\n", 1'b0);
        wait_for_quiet();
    endtask

    // More fields than the saturation limit; expect the count to stick at MAX_FIELDS.
    task automatic test_field_overflow();
        sender_gaps   = 1'b1;
        result_stalls = 1'b1;
        apply_settings(RST_SEPARATOR, RST_QUOTE, 16'(MAX_FIELDS));
        repeat (260) send_unit(cfg_separator, 1'b0);
        send_unit(LINE_FEED, 1'b0);
        wait_for_quiet();
    endtask

    // Hold results off while units keep coming, then pause until all land.
    task automatic test_backpressure_fill();
        sender_gaps = 1'b0;
        apply_settings(16'd59, RST_QUOTE, 16'd3);
        hold_req = 1'b1;
        while (!holding)
            @(posedge i_clk);
        while (holding)
            send_record();
        repeat (3) send_record();
        wait_for_quiet();
    endtask

    task automatic pick_random_settings(input int phase);
        logic [UNIT_W-1:0] sep;
        logic [UNIT_W-1:0] quo;
        logic [UNIT_W-1:0] expct;
        case (phase % 6)
            0: begin sep = RST_SEPARATOR; quo = RST_QUOTE; end
            1: begin sep = 16'd59; quo = RST_QUOTE; end
            2: begin sep = 16'hFFFF; quo = 16'h0000; end
            3: begin sep = UNIT_W'($urandom_range(0, 65535)); quo = sep; end
            4: begin sep = LINE_FEED; quo = UNIT_W'($urandom_range(0, 65535)); end
            default: begin
                sep = UNIT_W'($urandom_range(0, 65535));
                quo = UNIT_W'($urandom_range(0, 65535));
            end
        endcase
        // Small counts give frequent matches; the odd wide value tests masking.
        case ($urandom_range(0, 7))
            0: expct = 16'd0;
            1: expct = 16'(MAX_FIELDS);
            2: expct = UNIT_W'($urandom_range(0, 65535));
            default: expct = UNIT_W'($urandom_range(1, 5));
        endcase
        apply_settings(sep, quo, expct);
    endtask

    // Phases of random records and noise, each under fresh settings.
    task automatic test_random_streams();
        int phase_end;
        for (int phase = 0; phase < 7; phase++) begin
            wait_for_quiet();
            pick_random_settings(phase);
            // One phase runs flat out on both sides.
            sender_gaps   = (phase != 2);
            result_stalls = (phase != 2);
            phase_end = units_sent + RANDOM_UNITS / 7;
            while (units_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_record();
            end
        end
        wait_for_quiet();
    endtask

    initial begin
        apply_reset();
        test_basic_records();
        test_register_extremes();
        test_field_overflow();
        test_backpressure_fill();
        test_random_streams();
        wait_for_quiet();
        $display("Covered %0d code units under %0d register settings, with stalls and a long hold.",
                 units_sent, settings_used);
        $display("Checked %0d tokens: %0d records closed, %0d of them matching.",
                 tokens_checked, records_seen, matches_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
